>>> design/bitmap_first_free_allocator_top_defines.svh
// Assertion macros for the bitmap first-free allocator.
// Included by the top level; expects clk and rst_n in scope.
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define BFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/bfa_pkg.sv
// Shared types, codes and helpers for the bitmap first-free allocator.
// No dependencies; used by bfa_bitmap_ram, bfa_ctrl and the top level.
package bfa_pkg;

  localparam int MAX_BITMAP_BYTES_DEF = 4096;
  localparam int BASE_LENGTH = 1024;
  localparam int LEN_W = 14;
  localparam int ROW_BYTES = 8;
  localparam int ROW_BITS = 64;
  localparam logic [7:0] BYTE_FULL = 8'hff;

  localparam logic [0:0] REG_LOG_BLOCK_SIZE = 1'b0;
  localparam logic [0:0] REG_NUMBER_BASE = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD      = 2'd0,
    CMD_ALLOC     = 2'd1,
    CMD_MARK_USED = 2'd2,
    CMD_MARK_FREE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t        command;
    logic [15:0] item_number;
    logic [11:0] load_index;
    logic [7:0]  load_byte;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] allocated_number;
  } rsp_t;

  typedef struct packed {
    logic [1:0] log_block_size;
    logic       number_base;
  } cfg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_MODIFY,
    S_SCAN,
    S_DONE
  } state_t;

  // lowest clear bit of a bitmap row
  function automatic logic [5:0] first_zero(input logic [ROW_BITS-1:0] w);
    logic [5:0] pos;
    pos = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (!w[i]) pos = 6'(i);
    end
    return pos;
  endfunction

  // bytes past the end of a partial last row read as full
  function automatic logic [ROW_BITS-1:0] tail_pad(input int tail);
    logic [ROW_BITS-1:0] pad;
    pad = '0;
    for (int i = 0; i < ROW_BYTES; i++) begin
      if (tail != 0 && i >= tail) pad[i*8 +: 8] = BYTE_FULL;
    end
    return pad;
  endfunction

endpackage

>>> design/bfa_bitmap_ram.sv
// Bitmap store: 64-bit rows with byte write enables and a registered read.
// Depends on bfa_pkg.
module bfa_bitmap_ram #(
  parameter int MAX_BITMAP_BYTES = bfa_pkg::MAX_BITMAP_BYTES_DEF,
  parameter int ROWS = (MAX_BITMAP_BYTES + 7) / 8,
  parameter int ROW_AW = $clog2(ROWS)
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [ROW_AW-1:0]             wr_addr,
  input  logic [bfa_pkg::ROW_BYTES-1:0] wr_be,
  input  logic [bfa_pkg::ROW_BITS-1:0]  wr_data,
  input  logic                          rd_en,
  input  logic [ROW_AW-1:0]             rd_addr,
  output logic [bfa_pkg::ROW_BITS-1:0]  rd_data
);
  import bfa_pkg::*;

  logic [ROW_BITS-1:0] mem [ROWS];
  logic [ROW_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < ROW_BYTES; i++) begin
      if (wr_en && wr_be[i]) mem[wr_addr][i*8 +: 8] <= wr_data[i*8 +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/bfa_ctrl.sv
// Sequencer: clearing pass, command decode, read-modify-write and the row scan
// with the shared first-zero finder. Depends on bfa_pkg.
module bfa_ctrl #(
  parameter int MAX_BITMAP_BYTES = bfa_pkg::MAX_BITMAP_BYTES_DEF,
  parameter int ROWS = (MAX_BITMAP_BYTES + 7) / 8,
  parameter int ROW_AW = $clog2(ROWS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bfa_pkg::cfg_t                 cfg,
  input  logic                          start,
  input  bfa_pkg::req_t                 in_req,
  output logic                          busy,
  output logic                          out_valid,
  output bfa_pkg::rsp_t                 out_rsp,
  output logic                          wr_en,
  output logic [ROW_AW-1:0]             wr_addr,
  output logic [bfa_pkg::ROW_BYTES-1:0] wr_be,
  output logic [bfa_pkg::ROW_BITS-1:0]  wr_data,
  output logic                          rd_en,
  output logic [ROW_AW-1:0]             rd_addr,
  input  logic [bfa_pkg::ROW_BITS-1:0]  rd_data
);
  import bfa_pkg::*;

  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);
  localparam logic [ROW_BITS-1:0] TAIL_PAD = tail_pad(MAX_BITMAP_BYTES % ROW_BYTES);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BITMAP_BYTES);

  state_t            state_r, state_nxt;
  req_t              req_r, req_nxt;
  rsp_t              rsp_r, rsp_nxt;
  logic [ROW_AW-1:0] row_r, row_nxt;

  logic [LEN_W-1:0]    base_len, len_bytes, rows_act;
  logic [ROW_AW-1:0]   last_row_act;
  logic [15:0]         bitn;
  logic                range_bad;
  logic                load_ok;
  logic [ROW_AW-1:0]   mark_row;
  logic [ROW_BITS-1:0] mark_mask;
  logic [ROW_BITS-1:0] scan_word;
  logic                scan_hit;
  logic [5:0]          scan_pos;

  assign base_len     = LEN_W'(BASE_LENGTH) << cfg.log_block_size;
  assign len_bytes    = (base_len > MAX_LEN) ? MAX_LEN : base_len;
  assign rows_act     = (len_bytes + LEN_W'(7)) >> 3;
  assign last_row_act = ROW_AW'(rows_act - LEN_W'(1));

  assign bitn      = req_r.item_number - {15'd0, cfg.number_base};
  assign range_bad = (req_r.item_number < {15'd0, cfg.number_base}) ||
                     ({1'b0, bitn} >= {len_bytes, 3'b000});
  assign load_ok   = {2'b00, req_r.load_index} < MAX_LEN;
  assign mark_row  = ROW_AW'(bitn >> 6);
  assign mark_mask = ROW_BITS'(1) << bitn[5:0];

  assign scan_word = rd_data | ((row_r == LAST_ROW) ? TAIL_PAD : '0);
  assign scan_hit  = ~&scan_word;
  assign scan_pos  = first_zero(scan_word);

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_rsp   = rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    rsp_r <= rsp_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    rsp_nxt   = rsp_r;
    row_nxt   = row_r;
    wr_en     = 1'b0;
    wr_addr   = row_r;
    wr_be     = '0;
    wr_data   = '0;
    rd_en     = 1'b0;
    rd_addr   = row_r;
    case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
        wr_be = '1;
        if (row_r == LAST_ROW) begin
          row_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          row_nxt = row_r + ROW_AW'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        rsp_nxt.allocated_number = '0;
        case (req_r.command)
          CMD_LOAD: begin
            state_nxt = S_DONE;
            if (load_ok) begin
              wr_en          = 1'b1;
              wr_addr        = ROW_AW'(req_r.load_index >> 3);
              wr_be          = ROW_BYTES'(1) << req_r.load_index[2:0];
              wr_data        = {ROW_BYTES{req_r.load_byte}};
              rsp_nxt.status = STATUS_OK;
            end else begin
              rsp_nxt.status = STATUS_RANGE;
            end
          end
          CMD_ALLOC: begin
            rd_en     = 1'b1;
            rd_addr   = '0;
            row_nxt   = '0;
            state_nxt = S_SCAN;
          end
          default: begin
            if (range_bad) begin
              rsp_nxt.status = STATUS_RANGE;
              state_nxt      = S_DONE;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = mark_row;
              state_nxt = S_MODIFY;
            end
          end
        endcase
      end
      S_MODIFY: begin
        wr_en   = 1'b1;
        wr_be   = '1;
        wr_addr = mark_row;
        wr_data = (req_r.command == CMD_MARK_USED) ? (rd_data | mark_mask)
                                                   : (rd_data & ~mark_mask);
        rsp_nxt.status           = STATUS_OK;
        rsp_nxt.allocated_number = '0;
        state_nxt                = S_DONE;
      end
      S_SCAN: begin
        if (scan_hit) begin
          wr_en   = 1'b1;
          wr_be   = '1;
          wr_addr = row_r;
          wr_data = rd_data | (ROW_BITS'(1) << scan_pos);
          rsp_nxt.status           = STATUS_OK;
          rsp_nxt.allocated_number = 16'({row_r, scan_pos}) + {15'd0, cfg.number_base};
          state_nxt                = S_DONE;
        end else if (row_r == last_row_act) begin
          rsp_nxt.status           = STATUS_FULL;
          rsp_nxt.allocated_number = '0;
          state_nxt                = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = row_r + ROW_AW'(1);
          row_nxt = row_r + ROW_AW'(1);
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/bitmap_first_free_allocator_top.sv
// Top level of the bitmap first-free allocator: configuration registers,
// sequencer and bitmap store. Depends on bfa_pkg, bfa_ctrl, bfa_bitmap_ram.
//
// Usage:
//   Requests enter on in_req when start is high and busy is low. Each request
//   gives exactly one response on out_rsp, marked by a one-cycle out_valid
//   pulse that the receiver must take; there is no back-pressure.
//   Configuration (cfg_we, cfg_index, cfg_wdata) is to be written only while
//   idle; the block itself does not enforce this. Index 0 is log_block_size,
//   index 1 is number_base.
//   Mark used and mark free read and rewrite the row, skipping this when the
//   item is out of range; allocate scans rows, up to active bytes / 8
//   (512 at 4096 bytes), until it finds a clear bit.
//   One request in flight; busy drops after the response, so the next request
//   can be accepted in the cycle after it.
//   The allocate scan reads one 64-bit row per cycle through the single read
//   port and runs the first-zero finder on it. After reset the store is
//   cleared one row per cycle, all (MAX_BITMAP_BYTES + 7) / 8 rows (512 by
//   default), with busy high; configuration resets to zero.
`include "bitmap_first_free_allocator_top_defines.svh"

module bitmap_first_free_allocator_top #(
  parameter int MAX_BITMAP_BYTES = bfa_pkg::MAX_BITMAP_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  bfa_pkg::req_t in_req,
  output logic          out_valid,
  output bfa_pkg::rsp_t out_rsp,
  input  logic          cfg_we,
  input  logic [0:0]    cfg_index,
  input  logic [1:0]    cfg_wdata
);
  import bfa_pkg::*;

  localparam int ROWS = (MAX_BITMAP_BYTES + 7) / 8;
  localparam int ROW_AW = $clog2(ROWS);

  cfg_t cfg_r;

  logic                wr_en;
  logic [ROW_AW-1:0]   wr_addr;
  logic [ROW_BYTES-1:0] wr_be;
  logic [ROW_BITS-1:0] wr_data;
  logic                rd_en;
  logic [ROW_AW-1:0]   rd_addr;
  logic [ROW_BITS-1:0] rd_data;
  logic                rsp_fail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOG_BLOCK_SIZE: cfg_r.log_block_size <= cfg_wdata;
        REG_NUMBER_BASE:    cfg_r.number_base    <= cfg_wdata[0];
        default:            cfg_r                <= cfg_r;
      endcase
    end
  end

  bfa_ctrl #(
    .MAX_BITMAP_BYTES(MAX_BITMAP_BYTES),
    .ROWS(ROWS),
    .ROW_AW(ROW_AW)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .cfg(cfg_r),
    .start(start),
    .in_req(in_req),
    .busy(busy),
    .out_valid(out_valid),
    .out_rsp(out_rsp),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_be(wr_be),
    .wr_data(wr_data),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  bfa_bitmap_ram #(
    .MAX_BITMAP_BYTES(MAX_BITMAP_BYTES),
    .ROWS(ROWS),
    .ROW_AW(ROW_AW)
  ) u_ram (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_be(wr_be),
    .wr_data(wr_data),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign rsp_fail = out_valid && (out_rsp.status != STATUS_OK);

  `BFA_ASSERT_NOW(a_resp_while_busy, out_valid, busy, "response outside a request")
  `BFA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `BFA_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "response strobe held too long")
  `BFA_ASSERT_NOW(a_zero_on_fail, rsp_fail, out_rsp.allocated_number == 16'd0, "failure with a number")

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Testbench for bitmap_first_free_allocator_top: directed and random requests with a bitmap
// predictor, responses checked in order. Depends on bfa_pkg and the allocator RTL.
module testbench;
  import bfa_pkg::*;

  localparam int MAP_DEPTH = MAX_BITMAP_BYTES_DEF;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  req_t       in_req = '0;
  logic       out_valid;
  rsp_t       out_rsp;
  logic       cfg_we = 1'b0;
  logic [0:0] cfg_index = REG_LOG_BLOCK_SIZE;
  logic [1:0] cfg_wdata = 2'd0;

  logic [7:0] shadow_map [MAP_DEPTH];
  int         shadow_log = 0;
  int         shadow_base = 0;
  req_t       requests_todo [$];
  rsp_t       answers_due [$];
  int         idle_left = 0;
  bit         calm = 1'b0;
  int         err_count = 0;

  int phase_log  [8] = '{1, 3, 0, 2, 3, 1, 0, 2};
  int phase_base [8] = '{0, 1, 1, 0, 0, 1, 0, 1};

  bitmap_first_free_allocator_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int map_bytes();
    int n;
    n = 1024 << shadow_log;
    if (n > MAP_DEPTH) n = MAP_DEPTH;
    return n;
  endfunction

  function automatic rsp_t allocator_answer(input req_t rq);
    rsp_t       r;
    int         nbytes;
    int         idx;
    int         b;
    int         bitn;
    logic [7:0] v;
    r.status = STATUS_OK;
    r.allocated_number = '0;
    nbytes = map_bytes();
    case (rq.command)
      CMD_LOAD: begin
        if (int'(rq.load_index) < MAP_DEPTH) shadow_map[rq.load_index] = rq.load_byte;
        else r.status = STATUS_RANGE;
      end
      CMD_ALLOC: begin
        idx = 0;
        while (idx < nbytes && shadow_map[idx] == BYTE_FULL) idx++;
        if (idx == nbytes) begin
          r.status = STATUS_FULL;
        end else begin
          v = shadow_map[idx];
          b = 0;
          while (b < 7 && v[b]) b++;
          shadow_map[idx] = v | (8'd1 << b);
          r.allocated_number = 16'(idx * 8 + b + shadow_base);
        end
      end
      CMD_MARK_USED, CMD_MARK_FREE: begin
        if (int'(rq.item_number) < shadow_base) begin
          r.status = STATUS_RANGE;
        end else begin
          bitn = int'(rq.item_number) - shadow_base;
          if (bitn >= nbytes * 8) r.status = STATUS_RANGE;
          else if (rq.command == CMD_MARK_USED) shadow_map[bitn >> 3][bitn & 7] = 1'b1;
          else shadow_map[bitn >> 3][bitn & 7] = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int draw_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input rsp_t got, input rsp_t want);
    $display("MISMATCH %s: got status %0d number %0d, want status %0d number %0d",
             what, got.status, got.allocated_number, want.status, want.allocated_number);
    err_count++;
  endtask

  task automatic push_req(input cmd_t c, input int item, input int idx, input int bv);
    req_t rq;
    rq.command     = c;
    rq.item_number = 16'(item);
    rq.load_index  = 12'(idx);
    rq.load_byte   = 8'(bv);
    requests_todo.push_back(rq);
  endtask

  task automatic settle();
    do @(negedge clk);
    while (requests_todo.size() != 0 || start || answers_due.size() != 0 || busy);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 2'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_LOG_BLOCK_SIZE) shadow_log = val;
    else shadow_base = val;
    @(negedge clk);
  endtask

  task automatic set_config(input int log_size, input int base);
    settle();
    write_reg(REG_LOG_BLOCK_SIZE, log_size);
    write_reg(REG_NUMBER_BASE, base);
    calm = ($urandom_range(0, 3) == 0);
  endtask

  task automatic fill_map_full();
    int nbits;
    int i;
    nbits = map_bytes() * 8;
    for (i = 0; i < map_bytes(); i++) begin
      push_req(CMD_LOAD, $urandom, i, BYTE_FULL);
      if ($urandom_range(0, 63) == 0) push_req(CMD_ALLOC, $urandom, $urandom, $urandom);
    end
    push_req(CMD_ALLOC, 0, 0, 0);
    push_req(CMD_MARK_FREE, shadow_base + $urandom_range(0, nbits - 1), 0, 0);
    push_req(CMD_ALLOC, 0, 0, 0);
    push_req(CMD_ALLOC, 0, 0, 0);
    push_req(CMD_MARK_FREE, 0, 0, 0);
    push_req(CMD_MARK_USED, nbits + shadow_base, 0, 0);
  endtask

  task automatic add_random_items(input int count);
    req_t rq;
    int   nbits;
    int   sel;
    int   k;
    int   hi;
    nbits = map_bytes() * 8;
    hi = (nbits - 1 < 1023) ? nbits - 1 : 1023;
    for (k = 0; k < count; k++) begin
      rq.item_number = 16'($urandom);
      rq.load_index  = 12'($urandom);
      rq.load_byte   = 8'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        rq.command = CMD_ALLOC;
      end else if (sel < 65) begin
        rq.command = CMD_LOAD;
        if ($urandom_range(0, 9) < 6) begin
          rq.load_index = 12'($urandom_range(0, 127));
          if ($urandom_range(0, 2) != 0) rq.load_byte = BYTE_FULL;
        end
      end else begin
        rq.command = ($urandom_range(0, 1) != 0) ? CMD_MARK_USED : CMD_MARK_FREE;
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
          rq.item_number = 16'(shadow_base + $urandom_range(0, hi));
        end else if (sel < 65) begin
          rq.item_number = 16'($urandom);
        end else if (sel < 80) begin
          case ($urandom_range(0, 2))
            0: rq.item_number = 16'd0;
            1: rq.item_number = 16'(nbits + shadow_base - 1);
            default: rq.item_number = 16'(nbits + shadow_base);
          endcase
        end else begin
          rq.item_number = 16'(shadow_base + $urandom_range(0, nbits - 1));
        end
      end
      requests_todo.push_back(rq);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      idle_left = 0;
    end else begin
      if (start && !busy) begin
        answers_due.push_back(allocator_answer(in_req));
        idle_left = draw_gap();
      end
      if (!start || !busy) begin
        if (idle_left > 0) begin
          start <= 1'b0;
          idle_left--;
        end else if (requests_todo.size() != 0) begin
          in_req <= requests_todo.pop_front();
          start  <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_valid) begin
      if (answers_due.size() == 0) begin
        want = '0;
        report_mismatch("unexpected response", out_rsp, want);
      end else begin
        want = answers_due.pop_front();
        if (out_rsp.status !== want.status) report_mismatch("status", out_rsp, want);
        if (out_rsp.allocated_number !== want.allocated_number)
          report_mismatch("allocated number", out_rsp, want);
      end
    end
  end

  initial begin
    int p;
    foreach (shadow_map[i]) shadow_map[i] = 8'h00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    set_config(0, 0);
    push_req(CMD_ALLOC, 0, 0, 0);
    push_req(CMD_ALLOC, 0, 0, 0);
    push_req(CMD_LOAD, 0, 0, BYTE_FULL);
    push_req(CMD_ALLOC, 0, 0, 0);
    push_req(CMD_LOAD, 0, 1, 8'h7f);
    push_req(CMD_ALLOC, 0, 0, 0);
    push_req(CMD_LOAD, 16'hffff, 12'hfff, BYTE_FULL);
    push_req(CMD_LOAD, 0, 1023, 8'h00);
    push_req(CMD_MARK_USED, 0, 0, 0);
    push_req(CMD_MARK_FREE, 0, 0, 0);
    push_req(CMD_MARK_USED, 8191, 0, 0);
    push_req(CMD_MARK_FREE, 8191, 0, 0);
    push_req(CMD_MARK_USED, 8192, 0, 0);
    push_req(CMD_MARK_FREE, 16'hffff, 0, 0);
    push_req(CMD_LOAD, 0, 0, 8'h00);
    push_req(CMD_ALLOC, 0, 0, 0);

    set_config(3, 1);
    push_req(CMD_MARK_USED, 0, 0, 0);
    push_req(CMD_MARK_FREE, 0, 0, 0);
    push_req(CMD_MARK_USED, 32768, 0, 0);
    push_req(CMD_MARK_FREE, 32768, 0, 0);
    push_req(CMD_MARK_USED, 16'hffff, 0, 0);
    push_req(CMD_ALLOC, 0, 0, 0);

    set_config(0, 1);
    fill_map_full();

    for (p = 0; p < 8; p++) begin
      set_config(phase_log[p], phase_base[p]);
      add_random_items(4);
    end

    settle();
    repeat (20) @(negedge clk);
    if (err_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
